[rtl/core/nwl_pkg.sv]
// ----------------------------------------------------------------------------
// nwl_pkg
// Shared types, constants and the control program of the nearest waypoint
// lookahead core.
// ----------------------------------------------------------------------------
package nwl_pkg;

    // Default sizes
    localparam int NWL_MAX_POINTS = 256;
    localparam int NWL_COORD_BITS = 16;

    // Fixed field widths
    localparam int ACTION_W      = 2;
    localparam int LOOKAHEAD_W   = 8;
    localparam int GOAL_INDEX_W  = 8;

    // Register file
    localparam int                     APB_ADDR_W     = 3;
    localparam int                     APB_DATA_W     = 32;
    localparam logic [APB_ADDR_W-1:0]  REG_LOOKAHEAD  = 3'd0;
    localparam logic [LOOKAHEAD_W-1:0] LOOKAHEAD_RST  = 8'd2;

    // Item actions
    localparam logic [ACTION_W-1:0] ACT_NEW_PATH = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY    = 2'd2;

    // Program steps
    typedef logic [2:0] step_t;
    localparam step_t STEP_IDLE   = 3'd0;
    localparam step_t STEP_SCAN   = 3'd1;
    localparam step_t STEP_DRAIN1 = 3'd2;
    localparam step_t STEP_DRAIN2 = 3'd3;
    localparam step_t STEP_DRAIN3 = 3'd4;
    localparam step_t STEP_DRAIN4 = 3'd5;
    localparam step_t STEP_SELECT = 3'd6;
    localparam step_t STEP_EMIT   = 3'd7;

    // Branch conditions: jump to target when true, else hold the step
    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_QUERY,
        COND_SCAN_DONE,
        COND_OUT_FREE
    } cond_t;

    // One control word
    typedef struct packed {
        logic  accept;   // take an input item
        logic  scan;     // read point at scan address, feed distance pipe
        logic  select;   // pick goal index, read goal point
        logic  emit;     // load the output register
        cond_t cond;
        step_t target;
    } ctrl_t;

    // Status from datapath to sequencer
    typedef struct packed {
        logic query_go;
        logic scan_last;
        logic out_free;
    } flags_t;

    // Control store
    function automatic ctrl_t nwl_ucode(input step_t step);
        ctrl_t w;
        w = '0;
        case (step)
            STEP_IDLE: begin
                w.accept = 1'b1;
                w.cond   = COND_QUERY;
                w.target = STEP_SCAN;
            end
            STEP_SCAN: begin
                w.scan   = 1'b1;
                w.cond   = COND_SCAN_DONE;
                w.target = STEP_DRAIN1;
            end
            STEP_DRAIN1: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_DRAIN2;
            end
            STEP_DRAIN2: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_DRAIN3;
            end
            STEP_DRAIN3: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_DRAIN4;
            end
            STEP_DRAIN4: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_SELECT;
            end
            STEP_SELECT: begin
                w.select = 1'b1;
                w.cond   = COND_ALWAYS;
                w.target = STEP_EMIT;
            end
            STEP_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_FREE;
                w.target = STEP_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[rtl/core/nwl_seq.sv]
// ----------------------------------------------------------------------------
// nwl_seq
// Step counter and control store; emits one control word per cycle and
// takes conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module nwl_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  nwl_pkg::flags_t flags,
    output nwl_pkg::ctrl_t  ctrl
);
    import nwl_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  cond_true;

    // Control word of the current step
    assign ctrl = nwl_ucode(step_reg);

    // Branch condition
    always_comb begin
        case (ctrl.cond)
            COND_ALWAYS:    cond_true = 1'b1;
            COND_QUERY:     cond_true = flags.query_go;
            COND_SCAN_DONE: cond_true = flags.scan_last;
            COND_OUT_FREE:  cond_true = flags.out_free;
            default:        cond_true = 1'b1;
        endcase
        step_next = cond_true ? ctrl.target : step_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

[rtl/core/nwl_path_mem.sv]
// ----------------------------------------------------------------------------
// nwl_path_mem
// Waypoint store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nwl_path_mem #(
    parameter int DEPTH = nwl_pkg::NWL_MAX_POINTS,
    parameter int WIDTH = 2 * nwl_pkg::NWL_COORD_BITS,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/nwl_dist.sv]
// ----------------------------------------------------------------------------
// nwl_dist
// Squared-distance pipeline and running minimum. Points arrive one memory
// latency after their index is issued; the earliest point wins ties.
// ----------------------------------------------------------------------------
module nwl_dist #(
    parameter int MAX_POINTS = nwl_pkg::NWL_MAX_POINTS,
    parameter int COORD_BITS = nwl_pkg::NWL_COORD_BITS,
    localparam int AW        = $clog2(MAX_POINTS)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         issue_v,
    input  logic [AW-1:0]                issue_idx,
    input  logic signed [COORD_BITS-1:0] pt_x,
    input  logic signed [COORD_BITS-1:0] pt_y,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    output logic [AW-1:0]                best_idx
);
    localparam int C     = COORD_BITS;
    localparam int SQ_W  = 2 * C;
    localparam int SUM_W = 2 * C + 1;

    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    logic [AW-1:0]   i1_reg, i2_reg, i3_reg, i4_reg;
    logic [C:0]      dfx, dfy, negx, negy;
    logic [C-1:0]    adx, ady;
    logic [C-1:0]    dx_reg, dy_reg;
    logic [SQ_W-1:0] sqx_reg, sqy_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] best_dist_reg;
    logic [AW-1:0]   best_idx_reg;

    // Absolute differences at C+1 bits; magnitude fits C bits
    assign dfx  = {pt_x[C-1], pt_x} - {pos_x[C-1], pos_x};
    assign dfy  = {pt_y[C-1], pt_y} - {pos_y[C-1], pos_y};
    assign negx = -dfx;
    assign negy = -dfy;
    assign adx  = dfx[C] ? negx[C-1:0] : dfx[C-1:0];
    assign ady  = dfy[C] ? negy[C-1:0] : dfy[C-1:0];

    // Valid and index chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= issue_v;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Payload stages: diff, square, sum
    always_ff @(posedge aclk) begin
        i1_reg  <= issue_idx;
        i2_reg  <= i1_reg;
        i3_reg  <= i2_reg;
        i4_reg  <= i3_reg;
        dx_reg  <= adx;
        dy_reg  <= ady;
        sqx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        sum_reg <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
    end

    // Running minimum; index zero restarts the search
    always_ff @(posedge aclk) begin
        if (v4_reg && (i4_reg == '0 || sum_reg < best_dist_reg)) begin
            best_dist_reg <= sum_reg;
            best_idx_reg  <= i4_reg;
        end
    end

    assign best_idx = best_idx_reg;

endmodule

[rtl/core/nearest_waypoint_lookahead_core.sv]
// ----------------------------------------------------------------------------
// nearest_waypoint_lookahead_core
// Waypoint path store with nearest-point search and lookahead goal pick.
// ----------------------------------------------------------------------------
// Load items (action 0 new path, 1 append) are taken in the idle step; appends
// past MAX_POINTS are dropped. A query (action 2) on a path of N points runs
// an accept step, a scan of all N points through the store's single read port
// (one point per cycle), the drain steps of the distance pipeline, a step that
// picks and reads the goal point and one that loads the output register, which
// may stretch while a previous result is still held. A query on an empty path
// and action 3 produce no result. The at_final flag is sticky until reset; a
// new path does not clear it. No clearing pass runs after reset. The lookahead
// register sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module nearest_waypoint_lookahead_core #(
    parameter int  MAX_POINTS  = nwl_pkg::NWL_MAX_POINTS,
    parameter int  COORD_BITS  = nwl_pkg::NWL_COORD_BITS,
    localparam int IN_DATA_W   = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W  = ((2 * COORD_BITS + nwl_pkg::GOAL_INDEX_W + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [IN_DATA_W-1:0]               s_axis_tdata,  // pos_x, pos_y
    input  logic [nwl_pkg::ACTION_W-1:0]       s_axis_tuser,  // action
    // result channel
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [OUT_DATA_W-1:0]              m_axis_tdata,  // goal_x, goal_y, goal_index
    output logic [0:0]                         m_axis_tuser,  // at_final
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nwl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [nwl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [nwl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import nwl_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int SEL_W = ((AW > LOOKAHEAD_W) ? AW : LOOKAHEAD_W) + 1;

    ctrl_t  ctrl;
    flags_t flags;

    logic                   in_acc;
    logic [ACTION_W-1:0]    in_action;
    logic signed [C-1:0]    in_x, in_y;
    logic                   room;

    logic [LOOKAHEAD_W-1:0] lookahead_reg;
    logic [CW-1:0]          count_reg;
    logic                   final_reg;
    logic [AW-1:0]          addr_reg;
    logic signed [C-1:0]    pos_x_reg, pos_y_reg;
    logic [AW-1:0]          sel_reg;

    logic [CW-1:0]          count_m1;
    logic [AW-1:0]          last_idx;
    logic [AW-1:0]          best_idx;
    logic [SEL_W-1:0]       ahead;
    logic                   passed;
    logic                   final_next;
    logic [AW-1:0]          sel_calc;
    logic [SEL_W-1:0]       sel_wide;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic [2*C-1:0]         mem_rdata;

    logic                   out_free;
    logic                   m_valid_reg;
    logic signed [C-1:0]    goal_x_reg, goal_y_reg;
    logic [GOAL_INDEX_W-1:0] goal_index_reg;
    logic                   at_final_reg;

    // Input unpacking
    assign in_x      = s_axis_tdata[C-1:0];
    assign in_y      = s_axis_tdata[2*C-1:C];
    assign in_action = s_axis_tuser;
    assign s_axis_tready = ctrl.accept;
    assign in_acc    = s_axis_tvalid & ctrl.accept;
    assign room      = count_reg < CW'(MAX_POINTS);

    // Path bookkeeping
    assign count_m1 = count_reg - CW'(1);
    assign last_idx = count_m1[AW-1:0];

    // Goal selection from the nearest index
    assign ahead      = SEL_W'(best_idx) + SEL_W'(lookahead_reg);
    assign passed     = ahead > SEL_W'(last_idx);
    assign final_next = final_reg | passed;
    assign sel_calc   = final_next ? last_idx : ahead[AW-1:0];
    assign sel_wide   = SEL_W'(sel_reg);

    // Sequencer status
    assign out_free        = ~m_valid_reg | m_axis_tready;
    assign flags.query_go  = in_acc && (in_action == ACT_QUERY) && (count_reg != '0);
    assign flags.scan_last = addr_reg == last_idx;
    assign flags.out_free  = out_free;

    nwl_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    // Store ports
    assign mem_we    = in_acc && ((in_action == ACT_NEW_PATH) ||
                                  ((in_action == ACT_APPEND) && room));
    assign mem_waddr = (in_action == ACT_NEW_PATH) ? '0 : count_reg[AW-1:0];
    assign mem_re    = ctrl.scan | ctrl.select;
    assign mem_raddr = ctrl.scan ? addr_reg : sel_calc;

    nwl_path_mem #(
        .DEPTH (MAX_POINTS),
        .WIDTH (2 * C)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata ({in_y, in_x}),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    nwl_dist #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (C)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue_v   (ctrl.scan),
        .issue_idx (addr_reg),
        .pt_x      (mem_rdata[C-1:0]),
        .pt_y      (mem_rdata[2*C-1:C]),
        .pos_x     (pos_x_reg),
        .pos_y     (pos_y_reg),
        .best_idx  (best_idx)
    );

    // Control state: count, final flag, register, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            final_reg     <= 1'b0;
            lookahead_reg <= LOOKAHEAD_RST;
            m_valid_reg   <= 1'b0;
        end else begin
            if (in_acc && in_action == ACT_NEW_PATH) begin
                count_reg <= CW'(1);
            end else if (in_acc && in_action == ACT_APPEND && room) begin
                count_reg <= count_reg + CW'(1);
            end
            if (ctrl.select) begin
                final_reg <= final_next;
            end
            // word decode: byte offset bits are ignored
            if (psel && penable && pwrite && pready &&
                paddr[APB_ADDR_W-1:2] == REG_LOOKAHEAD[APB_ADDR_W-1:2]) begin
                lookahead_reg <= pwdata[LOOKAHEAD_W-1:0];
            end
            if (ctrl.emit && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            addr_reg  <= '0;
            pos_x_reg <= in_x;
            pos_y_reg <= in_y;
        end else if (ctrl.scan) begin
            addr_reg <= addr_reg + AW'(1);
        end
        if (ctrl.select) begin
            sel_reg <= sel_calc;
        end
        if (ctrl.emit && out_free) begin
            goal_x_reg     <= mem_rdata[C-1:0];
            goal_y_reg     <= mem_rdata[2*C-1:C];
            goal_index_reg <= sel_wide[GOAL_INDEX_W-1:0];
            at_final_reg   <= final_reg;
        end
    end

    // Result channel
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({goal_index_reg, goal_y_reg, goal_x_reg});
    assign m_axis_tuser  = at_final_reg;

    // Register read-back
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_LOOKAHEAD[APB_ADDR_W-1:2]) ?
                    APB_DATA_W'(lookahead_reg) : '0;

endmodule

[verif/tb_nearest_waypoint_lookahead_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_waypoint_lookahead_core
// Self-checking bench for the nearest waypoint lookahead core. A path shadow
// in the bench tracks every accepted load item and works out the goal that
// each query must return. Results are compared field by field in order.
// Directed checks cover the empty path, unused actions, extreme coordinates,
// distance ties, a full path and the sticky final flag. Random paths follow
// under several sender and receiver idling mixes and lookahead settings.
// ----------------------------------------------------------------------------
module tb_nearest_waypoint_lookahead_core;
    import nwl_pkg::*;

    localparam int CW             = NWL_COORD_BITS;
    localparam int MAXP           = NWL_MAX_POINTS;
    localparam int IN_W           = ((2 * CW + 7) / 8) * 8;
    localparam int OUT_W          = ((2 * CW + GOAL_INDEX_W + 7) / 8) * 8;
    localparam int DRAIN_CYCLES   = MAXP + 14;
    localparam int WATCHDOG_LIMIT = 4000;

    // action code the block must ignore
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t                  goal_x;
        coord_t                  goal_y;
        logic [GOAL_INDEX_W-1:0] goal_index;
        logic                    at_final;
    } goal_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata  = '0;  // pos_x, pos_y
    logic [ACTION_W-1:0]   s_axis_tuser  = '0;  // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;        // goal_x, goal_y, goal_index
    logic [0:0]            m_axis_tuser;        // at_final
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // path shadow and settings
    coord_t                 path_x [MAXP];
    coord_t                 path_y [MAXP];
    int                     path_len    = 0;
    logic                   final_flag  = 1'b0;
    logic [LOOKAHEAD_W-1:0] lookahead   = LOOKAHEAD_RST;
    goal_t                  pending_goals [$];

    int error_count        = 0;
    int results_seen       = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    nearest_waypoint_lookahead_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    // exact squared distance, wide enough for opposite corners
    function automatic logic [2*CW+1:0] dist_sq(input coord_t ax, input coord_t ay,
                                              input coord_t bx, input coord_t by);
        logic signed [CW:0] dx;
        logic signed [CW:0] dy;
        dx = ax - bx;
        dy = ay - by;
        return dx * dx + dy * dy;
    endfunction

    // first stored point at the least distance
    function automatic int nearest_point(input coord_t qx, input coord_t qy);
        int               best;
        int               i;
        logic [2*CW+1:0]  best_d;
        logic [2*CW+1:0]  d;
        best   = 0;
        best_d = dist_sq(path_x[0], path_y[0], qx, qy);
        for (i = 1; i < path_len; i++) begin
            d = dist_sq(path_x[i], path_y[i], qx, qy);
            if (d < best_d) begin
                best_d = d;
                best   = i;
            end
        end
        return best;
    endfunction

    // update the path shadow and queue the goal a query must produce
    task automatic apply_waypoint_item(input logic [ACTION_W-1:0] act,
                                       input coord_t x, input coord_t y);
        int    best;
        int    sel;
        goal_t g;
        case (act)
            ACT_NEW_PATH: begin
                path_x[0] = x;
                path_y[0] = y;
                path_len  = 1;
            end
            ACT_APPEND: begin
                if (path_len < MAXP) begin
                    path_x[path_len] = x;
                    path_y[path_len] = y;
                    path_len++;
                end
            end
            ACT_QUERY: begin
                if (path_len != 0) begin
                    best = nearest_point(x, y);
                    if (best + lookahead > path_len - 1)
                        final_flag = 1'b1;
                    sel = final_flag ? path_len - 1 : best + lookahead;
                    g.goal_x     = path_x[sel];
                    g.goal_y     = path_y[sel];
                    g.goal_index = sel[GOAL_INDEX_W-1:0];
                    g.at_final   = final_flag;
                    pending_goals.push_back(g);
                end
            end
            default: ;
        endcase
    endtask

    // drive one item, wait for acceptance, update the shadow
    task automatic send_item(input logic [ACTION_W-1:0] act, input coord_t x, input coord_t y);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tuser  <= act;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        apply_waypoint_item(act, x, y);
    endtask

    // drop valid, let all goals arrive, then let trailing loads settle
    task automatic wait_idle();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_goals.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_lookahead(input logic [LOOKAHEAD_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_LOOKAHEAD;
        pwdata  <= APB_DATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        lookahead = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly full range, sometimes a tight cluster so ties show up
    function automatic coord_t rand_coord();
        if ($urandom_range(3) == 0)
            return coord_t'($urandom_range(16)) - coord_t'(8);
        return coord_t'($urandom);
    endfunction

    // query at a given spot; unless allowed, steer away from setting the final flag
    task automatic send_query_at(input coord_t qx, input coord_t qy, input bit allow_final);
        if (!allow_final && path_len != 0 &&
            nearest_point(qx, qy) + lookahead > path_len - 1) begin
            if (lookahead > path_len - 1) begin
                send_item(ACT_APPEND, rand_coord(), rand_coord());
                return;
            end
            qx = path_x[0];
            qy = path_y[0];
        end
        send_item(ACT_QUERY, qx, qy);
    endtask

    // query near a stored point, or anywhere
    task automatic send_query(input bit allow_final);
        coord_t qx;
        coord_t qy;
        int     idx;
        int     top;
        if (path_len == 0 || $urandom_range(3) == 0) begin
            qx = coord_t'($urandom);
            qy = coord_t'($urandom);
        end else begin
            top = path_len - 1;
            if (!allow_final && top >= lookahead)
                top = top - lookahead;
            idx = $urandom_range(top);
            qx  = path_x[idx] + coord_t'(int'($urandom_range(64)) - 32);
            qy  = path_y[idx] + coord_t'(int'($urandom_range(64)) - 32);
        end
        send_query_at(qx, qy, allow_final);
    endtask

    // empty path, unused action, reset lookahead of two
    task automatic test_reset_defaults();
        send_item(ACT_QUERY, 16'sd0, 16'sd0);
        send_item(ACT_UNUSED, 16'sd5, -16'sd5);
        send_item(ACT_NEW_PATH, 16'sd0, 16'sd0);
        send_item(ACT_APPEND, 16'sd100, 16'sd0);
        send_item(ACT_APPEND, 16'sd200, 16'sd0);
        send_item(ACT_APPEND, 16'sd300, 16'sd0);
        send_item(ACT_APPEND, 16'sd400, 16'sd0);
        send_item(ACT_QUERY, 16'sd0, 16'sd0);
        send_item(ACT_QUERY, 16'sd110, 16'sd5);
        send_item(ACT_QUERY, -16'sd32768, 16'sd32767);
    endtask

    // corner-to-corner distances above 32 bits, and ties won by the earlier point
    task automatic test_extreme_coords();
        wait_idle();
        write_lookahead(8'd0);
        send_item(ACT_NEW_PATH, -16'sd32768, -16'sd32768);
        send_item(ACT_APPEND, -16'sd32768, 16'sd32767);
        send_item(ACT_QUERY, 16'sd32767, 16'sd32767);
        send_item(ACT_QUERY, 16'sd32767, -16'sd32768);
        send_item(ACT_NEW_PATH, 16'sd100, 16'sd0);
        send_item(ACT_APPEND, -16'sd100, 16'sd0);
        send_item(ACT_APPEND, 16'sd0, 16'sd100);
        send_item(ACT_APPEND, 16'sd0, -16'sd100);
        send_item(ACT_APPEND, 16'sd32767, -16'sd32768);
        send_item(ACT_QUERY, 16'sd0, 16'sd0);
        send_item(ACT_QUERY, -16'sd1, -16'sd1);
        send_item(ACT_QUERY, 16'sd32767, -16'sd32768);
        send_item(ACT_UNUSED, -16'sd1, -16'sd1);
        send_item(ACT_QUERY, 16'sd0, 16'sd0);
    endtask

    // fill the store, then appends that must be dropped
    task automatic test_path_full();
        coord_t drop_x [4];
        coord_t drop_y [4];
        int     i;
        wait_idle();
        write_lookahead(8'd1);
        sender_idle_pct    = 20;
        receiver_stall_pct = 20;
        send_item(ACT_NEW_PATH, coord_t'($urandom), coord_t'($urandom));
        for (i = 1; i < MAXP; i++)
            send_item(ACT_APPEND, coord_t'($urandom), coord_t'($urandom));
        for (i = 0; i < 4; i++) begin
            drop_x[i] = coord_t'($urandom);
            drop_y[i] = coord_t'($urandom);
            send_item(ACT_APPEND, drop_x[i], drop_y[i]);
        end
        send_item(ACT_QUERY, path_x[MAXP-2], path_y[MAXP-2]);
        send_item(ACT_QUERY, path_x[0], path_y[0]);
        for (i = 0; i < 4; i++)
            send_query_at(drop_x[i], drop_y[i], 1'b0);
        repeat (4) send_query(1'b0);
    endtask

    // random paths: mostly load-then-query sequences, some noise
    task automatic test_random_paths(input int sender_pct, input int stall_pct,
                                     input logic [LOOKAHEAD_W-1:0] offset,
                                     input int n_items, input bit allow_final);
        int sent;
        int kind;
        int n;
        wait_idle();
        write_lookahead(offset);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(99);
            if (kind < 65) begin
                if ($urandom_range(99) < 80)
                    n = $urandom_range(1, 30);
                else if ($urandom_range(99) < 75)
                    n = $urandom_range(31, 120);
                else
                    n = $urandom_range(200, 270);
                send_item(ACT_NEW_PATH, rand_coord(), rand_coord());
                sent++;
                repeat (n) begin
                    sent += (path_len < MAXP);
                    send_item(ACT_APPEND, rand_coord(), rand_coord());
                end
                n = $urandom_range(1, 6);
                repeat (n) begin
                    send_query(allow_final);
                    sent++;
                end
            end else if (kind < 80) begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    sent += (path_len < MAXP);
                    send_item(ACT_APPEND, rand_coord(), rand_coord());
                end
                send_query(allow_final);
                sent++;
            end else if (kind < 90) begin
                // unused action with random payload, then a query anywhere
                send_item(ACT_UNUSED, coord_t'($urandom), coord_t'($urandom));
                send_query_at(coord_t'($urandom), coord_t'($urandom), allow_final);
                sent++;
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    send_query(allow_final);
                    sent++;
                end
            end
        end
    endtask

    // flag set by passing the last point; a new path keeps it set
    task automatic test_final_flag();
        int i;
        wait_idle();
        write_lookahead(8'd1);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_item(ACT_NEW_PATH, 16'sd0, 16'sd0);
        for (i = 1; i < 6; i++)
            send_item(ACT_APPEND, coord_t'(i * 1000), coord_t'(-i * 1000));
        send_item(ACT_QUERY, 16'sd5000, -16'sd5000);
        send_item(ACT_QUERY, 16'sd0, 16'sd0);
        send_item(ACT_NEW_PATH, -16'sd500, -16'sd500);
        send_item(ACT_APPEND, 16'sd500, 16'sd500);
        send_item(ACT_APPEND, 16'sd1500, 16'sd1500);
        send_item(ACT_QUERY, -16'sd500, -16'sd500);
    endtask

    // result checker
    always @(posedge aclk) begin : check_results
        goal_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_goals.size() == 0) begin
                report_mismatch($sformatf("unexpected result, tdata %h tuser %b",
                                          m_axis_tdata, m_axis_tuser));
            end else begin
                want = pending_goals.pop_front();
                if (m_axis_tdata[CW-1:0] !== want.goal_x)
                    report_mismatch($sformatf("result %0d goal_x got %0d want %0d",
                        results_seen, $signed(m_axis_tdata[CW-1:0]), want.goal_x));
                if (m_axis_tdata[2*CW-1:CW] !== want.goal_y)
                    report_mismatch($sformatf("result %0d goal_y got %0d want %0d",
                        results_seen, $signed(m_axis_tdata[2*CW-1:CW]), want.goal_y));
                if (m_axis_tdata[2*CW+GOAL_INDEX_W-1:2*CW] !== want.goal_index)
                    report_mismatch($sformatf("result %0d goal_index got %0d want %0d",
                        results_seen, m_axis_tdata[2*CW+GOAL_INDEX_W-1:2*CW],
                        want.goal_index));
                if (m_axis_tuser[0] !== want.at_final)
                    report_mismatch($sformatf("result %0d at_final got %b want %b",
                        results_seen, m_axis_tuser[0], want.at_final));
            end
            results_seen++;
        end
    end

    // stop a hung run: too long without any handshake
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_extreme_coords();
        test_path_full();
        test_random_paths(0, 0, 8'd0, 150, 1'b0);
        test_random_paths(48, 0, 8'd3, 150, 1'b0);
        test_random_paths(0, 48, 8'd1, 150, 1'b0);
        test_random_paths(38, 38, 8'd5, 150, 1'b0);
        test_final_flag();
        test_random_paths(38, 38, 8'd255, 60, 1'b1);
        wait_idle();

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
